// ===== hw/rtl/tra_pkg.sv =====
// Shared types and constants of the timed reuse unit allocator.
// Used by tra_ctrl, tra_datapath and timed_reuse_unit_allocator_core; no dependencies.
`default_nettype none

package tra_pkg;

    localparam int SIZE_W     = 6;
    localparam int ADDR_W     = 48;
    localparam int STAMP_W    = 31;
    localparam int DELAY_W    = 8;
    localparam int UIU_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int MARK_W     = 32;
    localparam int CFG_IDX_W  = 2;

    // input word layout, lowest bit first
    localparam int IN_SIZE_LSB  = 0;
    localparam int IN_LO_LSB    = IN_SIZE_LSB + SIZE_W;
    localparam int IN_HI_LSB    = IN_LO_LSB + ADDR_W;
    localparam int IN_FADDR_LSB = IN_HI_LSB + ADDR_W;
    localparam int IN_NOW_LSB   = IN_FADDR_LSB + ADDR_W;
    localparam int IN_USED_W    = IN_NOW_LSB + STAMP_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_USED_W   = STATUS_W + ADDR_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [MARK_W-1:0] USED_BIT = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_NO_RUN     = 2'd1,
        ST_OUT_REGION = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_BASE  = 2'd0,
        CFG_UNITS_IN_USE = 2'd1,
        CFG_DELAY_TICKS  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic    load;
        logic    size_step;
        logic    scan_init;
        logic    scan;
        logic    take;
        logic    mread;
        logic    mwrite;
        logic    div_init;
        logic    div_step;
        logic    fwrite;
        logic    clear;
        logic    result_load;
        logic    with_addr;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic size_done;
        logic mode;
        logic n_bad;
        logic in_region;
        logic hit;
        logic scan_end;
        logic mark_last;
        logic div_done;
        logic free_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/tra_ctrl.sv =====
// Sequencer of the allocator: clear sweep, size rounding, scan, marking and free.
// Depends on tra_pkg; drives tra_datapath through t_cmd and reads t_stat.
`default_nettype none

module tra_ctrl
    import tra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_CHECK,
        S_SCAN,
        S_MREAD,
        S_MWRITE,
        S_FDIV,
        S_FWRITE,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_with_addr, n_with_addr;

    always_comb begin
        n_state         = r_state;
        n_code          = r_code;
        n_with_addr     = r_with_addr;
        o_cmd           = '0;
        o_cmd.code      = r_code;
        o_cmd.with_addr = r_with_addr;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SIZE;
                end
            end
            S_SIZE: begin
                if (i_stat.size_done) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.size_step = 1'b1;
                end
            end
            S_CHECK: begin
                if (!i_stat.mode) begin
                    if (i_stat.n_bad) begin
                        n_code      = ST_NO_RUN;
                        n_with_addr = 1'b0;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else begin
                    if (!i_stat.in_region) begin
                        n_code      = ST_OUT_REGION;
                        n_with_addr = 1'b0;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_FDIV;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_MREAD;
                end else if (i_stat.scan_end) begin
                    n_code      = ST_NO_RUN;
                    n_with_addr = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_MREAD: begin
                o_cmd.mread = 1'b1;
                n_state     = S_MWRITE;
            end
            S_MWRITE: begin
                o_cmd.mwrite = 1'b1;
                if (i_stat.mark_last) begin
                    n_code      = ST_DONE;
                    n_with_addr = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_MREAD;
                end
            end
            S_FDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FWRITE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FWRITE: begin
                if (i_stat.free_done) begin
                    n_code      = ST_DONE;
                    n_with_addr = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.fwrite = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= ST_DONE;
            r_with_addr <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_with_addr <= n_with_addr;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/tra_datapath.sv =====
// Datapath of the allocator: request registers, unit mark memory, scan pipeline,
// address arithmetic and result register. Depends on tra_pkg; commanded by tra_ctrl.
`default_nettype none

module tra_datapath
    import tra_pkg::*;
#(
    parameter int UNITS      = 256,
    parameter int UNIT_BYTES = 4,
    parameter int MAX_RUN    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic [ADDR_W-1:0]     i_region_base,
    input  logic [UIU_W-1:0]      i_units_in_use,
    input  logic [DELAY_W-1:0]    i_delay_ticks,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int IW    = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CW    = $clog2(UNITS + 1);
    localparam int XW    = (CW > UIU_W) ? CW : UIU_W;
    localparam int KW    = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int ACC_W = $clog2((1 << SIZE_W) + UNIT_BYTES);
    localparam int DW    = $clog2(UNITS * UNIT_BYTES + 1);
    localparam int EW    = ADDR_W + 1;
    localparam int NW    = (DW > SIZE_W + 1) ? DW : SIZE_W + 1;
    localparam int QSH   = NW + 5;
    localparam int PW    = NW + QSH + 1;
    localparam logic [QSH:0] RECIP = (QSH+1)'(((longint'(1) << QSH) + longint'(UNIT_BYTES) - 1)
                                              / longint'(UNIT_BYTES));

    function automatic logic [NW-1:0] div_units(input logic [NW-1:0] x);
        logic [PW-1:0] prod;
        prod = PW'(x) * PW'(RECIP);
        return prod[QSH +: NW];
    endfunction

    logic [MARK_W-1:0] r_mem [UNITS];

    logic                r_mode;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_lo, r_hi, r_faddr;
    logic [STAMP_W-1:0]  r_now;
    logic [ACC_W-1:0]    r_acc;
    logic [SIZE_W-1:0]   r_n;
    logic [EW-1:0]       r_end;
    logic [CW-1:0]       r_k;
    logic [ADDR_W-1:0]   r_saddr;
    logic                r_rv;
    logic [CW-1:0]       r_rk;
    logic [ADDR_W-1:0]   r_rsaddr;
    logic                r_rinr;
    logic [MARK_W-1:0]   r_rd;
    logic [SIZE_W-1:0]   r_run;
    logic [ADDR_W-1:0]   r_haddr;
    logic [CW-1:0]       r_last;
    logic [DW-1:0]       r_d;
    logic [SIZE_W-1:0]   r_cnt;
    logic                r_ovalid;
    t_status             r_ostatus;
    logic [ADDR_W-1:0]   r_oaddr;

    logic [XW-1:0]       w_uiu_x;
    logic [CW-1:0]       w_count;
    logic                w_k_lt;
    logic                w_scan_rd;
    logic [STAMP_W-1:0]  w_stamp;
    logic [STAMP_W-1:0]  w_age;
    logic                w_ready;
    logic [SIZE_W:0]     w_run_inc;
    logic                w_run_full;
    logic [SIZE_W-1:0]   w_run_next;
    logic                w_hit;
    logic                w_free_done;
    logic                w_we;
    logic                w_re;
    logic [MARK_W-1:0]   w_wdata;
    logic [SIZE_W-1:0]   w_n_calc;
    logic [CW-1:0]       w_first;

    assign w_uiu_x   = XW'(i_units_in_use);
    assign w_count   = (w_uiu_x > XW'(UNITS)) ? CW'(UNITS) : CW'(w_uiu_x);
    assign w_k_lt    = (r_k < w_count);
    assign w_scan_rd = i_cmd.scan && w_k_lt;

    assign w_n_calc  = SIZE_W'(div_units(NW'(r_size) + NW'(UNIT_BYTES - 1)));
    assign w_first   = CW'(div_units(NW'(r_d)));

    assign w_stamp    = r_rd[STAMP_W-1:0];
    assign w_age      = r_now - w_stamp;
    assign w_ready    = !r_rd[MARK_W-1] && (r_now > w_stamp)
                        && (w_age > STAMP_W'(i_delay_ticks));
    assign w_run_inc  = (SIZE_W+1)'(r_run) + (SIZE_W+1)'(1);
    assign w_run_full = (w_run_inc >= {1'b0, r_n});
    assign w_run_next = !w_ready ? '0 : (w_run_full ? r_n : w_run_inc[SIZE_W-1:0]);
    assign w_hit      = r_rv && w_ready && w_run_full && r_rinr;

    assign w_free_done = (r_cnt == r_n) || !w_k_lt;

    assign w_we    = i_cmd.clear || i_cmd.mwrite || (i_cmd.fwrite && !w_free_done);
    assign w_re    = w_scan_rd || i_cmd.mread;
    assign w_wdata = i_cmd.clear  ? '0 :
                     i_cmd.mwrite ? (r_rd | USED_BIT) :
                                    {1'b0, r_now};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_k[IW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_k[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rv <= w_scan_rd;
            priority if (i_cmd.load || i_cmd.div_init) begin
                r_k <= '0;
            end else if (i_cmd.take) begin
                r_k <= CW'(KW'(r_rk) + KW'(1) - KW'(r_n));
            end else if (i_cmd.div_step) begin
                r_k <= w_first;
            end else if (i_cmd.clear || w_scan_rd || i_cmd.mwrite
                         || (i_cmd.fwrite && !w_free_done)) begin
                r_k <= r_k + CW'(1);
            end else begin
                r_k <= r_k;
            end
            if (i_cmd.result_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end <= EW'(i_region_base) + EW'(w_count) * EW'(UNIT_BYTES);
        if (i_cmd.load) begin
            r_mode  <= i_s_tuser;
            r_size  <= i_s_tdata[IN_SIZE_LSB +: SIZE_W];
            r_lo    <= i_s_tdata[IN_LO_LSB +: ADDR_W];
            r_hi    <= i_s_tdata[IN_HI_LSB +: ADDR_W];
            r_faddr <= i_s_tdata[IN_FADDR_LSB +: ADDR_W];
            r_now   <= i_s_tdata[IN_NOW_LSB +: STAMP_W];
            r_acc   <= '0;
            r_n     <= '0;
        end
        if (i_cmd.size_step) begin
            r_acc <= ACC_W'(w_n_calc) * ACC_W'(UNIT_BYTES);
            r_n   <= w_n_calc;
        end
        if (i_cmd.scan_init) begin
            r_saddr <= i_region_base + ADDR_W'(UNIT_BYTES) - ADDR_W'(r_acc);
            r_run   <= '0;
        end
        if (w_scan_rd) begin
            r_saddr  <= r_saddr + ADDR_W'(UNIT_BYTES);
            r_rk     <= r_k;
            r_rsaddr <= r_saddr;
            r_rinr   <= (r_saddr >= r_lo) && (r_saddr <= r_hi);
        end
        if (i_cmd.scan && r_rv) begin
            r_run <= w_run_next;
        end
        if (i_cmd.take) begin
            r_haddr <= r_rsaddr;
            r_last  <= r_rk;
        end
        if (i_cmd.div_init) begin
            r_d   <= DW'(r_faddr - i_region_base);
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_d <= '0;
        end
        if (i_cmd.fwrite && !w_free_done) begin
            r_cnt <= r_cnt + SIZE_W'(1);
        end
        if (i_cmd.result_load) begin
            r_ostatus <= i_cmd.code;
            r_oaddr   <= i_cmd.with_addr ? r_haddr : '0;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.clear_last = (r_k == CW'(UNITS - 1));
        o_stat.size_done  = (r_acc >= ACC_W'(r_size));
        o_stat.mode       = r_mode;
        o_stat.n_bad      = (r_n == '0) || (r_n > SIZE_W'(MAX_RUN))
                            || (KW'(r_n) > KW'(w_count));
        o_stat.in_region  = ({1'b0, r_faddr} >= {1'b0, i_region_base})
                            && ({1'b0, r_faddr} < r_end);
        o_stat.hit        = w_hit;
        o_stat.scan_end   = !w_k_lt && !r_rv;
        o_stat.mark_last  = (r_k == r_last);
        o_stat.div_done   = (r_d < DW'(UNIT_BYTES));
        o_stat.free_done  = w_free_done;
        o_stat.out_free   = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), r_oaddr, r_ostatus};

endmodule

`default_nettype wire

// ===== hw/rtl/timed_reuse_unit_allocator_core.sv =====
// Top level of the timed reuse unit allocator: configuration registers, handshakes,
// controller and datapath. Depends on tra_pkg, tra_ctrl and tra_datapath.
//
//   channel   direction  handshake                    content
//   s_axis    in         s_axis_tvalid/s_axis_tready  request word, tuser = mode
//   m_axis    out        m_axis_tvalid/m_axis_tready  status and address word
//   cfg       in         i_cfg_valid/o_cfg_ready      register index and value
//
// After reset the unit marks are swept to zero with s_axis_tready low.
// Allocate is bound by the one mark memory port and the one-unit-per-cycle scan.
// One request at a time; a finished word waits in the output register while the next
// request is taken, and only the following result waits on m_axis_tready.
`default_nettype none

module timed_reuse_unit_allocator_core
    import tra_pkg::*;
#(
    parameter int UNITS      = 256,
    parameter int UNIT_BYTES = 4,
    parameter int MAX_RUN    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // size_bytes[5:0], start_lo[53:6], start_hi[101:54], free_address[149:102],
    // now[180:150], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], address[49:2], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data
);

    logic [ADDR_W-1:0]  r_region_base;
    logic [UIU_W-1:0]   r_units_in_use;
    logic [DELAY_W-1:0] r_delay_ticks;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= '0;
            r_units_in_use <= '0;
            r_delay_ticks  <= DELAY_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REGION_BASE:  r_region_base  <= i_cfg_data;
                CFG_UNITS_IN_USE: r_units_in_use <= i_cfg_data[UIU_W-1:0];
                CFG_DELAY_TICKS:  r_delay_ticks  <= i_cfg_data[DELAY_W-1:0];
                default: begin
                    r_region_base <= r_region_base;
                end
            endcase
        end
    end

    tra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_axis_tvalid && w_idle),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_idle   (w_idle)
    );

    tra_datapath #(
        .UNITS      (UNITS),
        .UNIT_BYTES (UNIT_BYTES),
        .MAX_RUN    (MAX_RUN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_region_base  (r_region_base),
        .i_units_in_use (r_units_in_use),
        .i_delay_ticks  (r_delay_ticks),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_addr_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != ST_DONE)
        |-> m_axis_tdata[STATUS_W +: ADDR_W] == '0)
        else $error("address returned without a completed allocation");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request taken before the mark sweep");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for timed_reuse_unit_allocator_core: allocate and free words with timed reuse.
// A mirror of the unit marks and registers predicts each status word; needs tra_pkg and the core.
module testbench
    import tra_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS         = 256;
    localparam int UNIT_BYTES    = 4;
    localparam int MAX_RUN       = 8;
    localparam int IDLE_PCT      = 26;
    localparam int SETTLE_CYCLES = 400;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        logic                mode;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   lo;
        logic [ADDR_W-1:0]   hi;
        logic [ADDR_W-1:0]   faddr;
        logic [STAMP_W-1:0]  now;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   address;
    } t_grant;

    typedef struct packed {
        logic [8:0]          first;
        logic [SIZE_W-1:0]   size;
    } t_live_run;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [ADDR_W-1:0]     i_cfg_data    = '0;

    logic [MARK_W-1:0]  mark_mirror [UNITS];
    logic [ADDR_W-1:0]  base_reg  = '0;
    logic [UIU_W-1:0]   units_reg = '0;
    logic [DELAY_W-1:0] delay_reg = 8'd3;
    logic [STAMP_W-1:0] now_tick  = '0;
    logic               stall_free = 1'b0;
    t_grant             grant_queue [$];
    t_live_run          live_runs [$];
    int                 grant_errors = 0;

    timed_reuse_unit_allocator_core #(
        .UNITS      (UNITS),
        .UNIT_BYTES (UNIT_BYTES),
        .MAX_RUN    (MAX_RUN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic unit_reusable(int idx, logic [STAMP_W-1:0] now);
        logic [MARK_W-1:0]  mark;
        logic [STAMP_W-1:0] stamp;
        mark  = mark_mirror[idx];
        stamp = mark[STAMP_W-1:0];
        if ((mark & USED_BIT) != 0)
            return 1'b0;
        if (now <= stamp)
            return 1'b0;
        return (now - stamp) > delay_reg;
    endfunction

    function automatic t_grant predict_grant(t_request r);
        t_grant            g;
        longint unsigned   span, run, start, probe, region_end, first;
        logic [ADDR_W-1:0] addr;
        logic              found;
        g.status  = ST_NO_RUN;
        g.address = '0;
        found     = 1'b0;
        span = (units_reg > UNITS) ? UNITS : units_reg;
        run  = (r.size + UNIT_BYTES - 1) / UNIT_BYTES;
        if (r.mode == MODE_ALLOC) begin
            if (run != 0 && run <= MAX_RUN && run <= span) begin
                start = 0;
                while (!found && start + run <= span) begin
                    addr = ADDR_W'(base_reg + UNIT_BYTES * start);
                    if (addr >= r.lo && addr <= r.hi) begin
                        probe = start;
                        while (probe < start + run && unit_reusable(int'(probe), r.now))
                            probe++;
                        if (probe < start + run) begin
                            start = probe;
                        end else begin
                            for (longint unsigned k = start; k < start + run; k++)
                                mark_mirror[k] = mark_mirror[k] | USED_BIT;
                            live_runs.push_back('{first: start[8:0], size: r.size});
                            g.status  = ST_DONE;
                            g.address = addr;
                            found     = 1'b1;
                        end
                    end
                    start++;
                end
            end
        end else begin
            region_end = base_reg + UNIT_BYTES * span;
            if (r.faddr < base_reg || r.faddr >= region_end) begin
                g.status = ST_OUT_REGION;
            end else begin
                first = (r.faddr - base_reg) / UNIT_BYTES;
                for (longint unsigned k = first; k < first + run && k < span; k++)
                    mark_mirror[k] = {1'b0, r.now};
                g.status = ST_DONE;
            end
        end
        return g;
    endfunction

    function automatic void flag_error(string field, logic [63:0] want, logic [63:0] got);
        grant_errors++;
        if (grant_errors <= 10)
            $display("%0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin : grant_check
        t_grant              want;
        logic [STATUS_W-1:0] got_status;
        logic [ADDR_W-1:0]   got_addr;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = m_axis_tdata[STATUS_W-1:0];
            got_addr   = m_axis_tdata[STATUS_W +: ADDR_W];
            if (grant_queue.size() == 0) begin
                flag_error("unexpected word", '0, m_axis_tdata);
            end else begin
                want = grant_queue.pop_front();
                if (got_status !== want.status)
                    flag_error("status", want.status, got_status);
                if (got_addr !== want.address)
                    flag_error("address", want.address, got_addr);
            end
        end
        m_axis_tready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                                input logic [ADDR_W-1:0] faddr, input logic [STAMP_W-1:0] now);
        t_request             r;
        logic [IN_DATA_W-1:0] word;
        r    = '{mode: mode, size: size, lo: lo, hi: hi, faddr: faddr, now: now};
        word = '0;
        word[IN_SIZE_LSB +: SIZE_W]  = size;
        word[IN_LO_LSB +: ADDR_W]    = lo;
        word[IN_HI_LSB +: ADDR_W]    = hi;
        word[IN_FADDR_LSB +: ADDR_W] = faddr;
        word[IN_NOW_LSB +: STAMP_W]  = now;
        while (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        grant_queue.push_back(predict_grant(r));
    endtask

    // hold off new words until every status word is back
    task automatic wait_for_grants();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (grant_queue.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [ADDR_W-1:0] value,
                             input logic last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last)
            i_cfg_valid <= 1'b0;
        case (idx)
            CFG_REGION_BASE:  base_reg  = value;
            CFG_UNITS_IN_USE: units_reg = value[UIU_W-1:0];
            CFG_DELAY_TICKS:  delay_reg = value[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [UIU_W-1:0] units,
                             input logic [DELAY_W-1:0] delay);
        write_reg(CFG_REGION_BASE, base, 1'b0);
        write_reg(CFG_UNITS_IN_USE, ADDR_W'(units), 1'b0);
        write_reg(CFG_DELAY_TICKS, ADDR_W'(delay), 1'b1);
    endtask

    task automatic test_reset_defaults();
        send_request(MODE_ALLOC, 6'd4, '0, ADDR_MAX, '0, 31'd100);
        send_request(MODE_FREE, 6'd4, '0, '0, '0, 31'd100);
        wait_for_grants();
        write_reg(CFG_UNITS_IN_USE, 48'd16, 1'b1);
        send_request(MODE_ALLOC, 6'd4, '0, ADDR_MAX, '0, 31'd3);
        send_request(MODE_ALLOC, 6'd4, '0, ADDR_MAX, '0, 31'd4);
    endtask

    task automatic test_size_limits();
        send_request(MODE_ALLOC, 6'd0, '0, ADDR_MAX, '0, 31'd10);
        send_request(MODE_ALLOC, 6'd33, '0, ADDR_MAX, '0, 31'd10);
        send_request(MODE_ALLOC, 6'd63, '0, ADDR_MAX, '0, 31'd10);
        send_request(MODE_ALLOC, 6'd32, '0, ADDR_MAX, '0, 31'd10);
        send_request(MODE_ALLOC, 6'd1, '0, ADDR_MAX, '0, 31'd10);
        send_request(MODE_FREE, 6'd0, '0, '0, 48'd4, 31'd10);
        send_request(MODE_FREE, 6'd4, '0, '0, 48'd64, 31'd10);
        send_request(MODE_FREE, 6'd32, '0, '0, 48'd60, 31'd10);
        send_request(MODE_FREE, 6'd4, ADDR_MAX, ADDR_MAX, ADDR_MAX, 31'h7FFF_FFFF);
    endtask

    task automatic test_reuse_timing();
        send_request(MODE_FREE, 6'd4, '0, '0, '0, 31'd20);
        send_request(MODE_ALLOC, 6'd4, '0, '0, '0, 31'd22);
        send_request(MODE_ALLOC, 6'd4, '0, '0, '0, 31'd23);
        send_request(MODE_ALLOC, 6'd4, '0, '0, '0, 31'd24);
        send_request(MODE_FREE, 6'd4, '0, '0, '0, 31'd100);
        send_request(MODE_ALLOC, 6'd4, '0, '0, '0, 31'd50);
        send_request(MODE_ALLOC, 6'd4, 48'd8, 48'd4, '0, 31'd200);
    endtask

    task automatic test_wrapped_region();
        wait_for_grants();
        configure(48'hFFFF_FFFF_FFF8, 9'd511, 8'd0);
        send_request(MODE_ALLOC, 6'd16, '0, 48'd64, '0, 31'd300);
        send_request(MODE_FREE, 6'd8, '0, '0, 48'hFFFF_FFFF_FFF8, 31'd300);
        send_request(MODE_FREE, 6'd4, '0, '0, '0, 31'd300);
        send_request(MODE_ALLOC, 6'd8, 48'hFFFF_FFFF_FFF8, ADDR_MAX, '0, 31'd301);
    endtask

    task automatic run_traffic(input int items, input int step_max);
        int                 pick, slot, span;
        logic               mode;
        logic [SIZE_W-1:0]  sz;
        logic [ADDR_W-1:0]  lo, hi, faddr;
        logic [STAMP_W-1:0] stamp;
        for (int k = 0; k < items; k++) begin
            span     = (units_reg > UNITS) ? UNITS : int'(units_reg);
            now_tick = now_tick + STAMP_W'($urandom_range(0, step_max));
            pick     = $urandom_range(0, 99);
            if (pick < 35 && live_runs.size() != 0) begin
                slot  = $urandom_range(0, live_runs.size() - 1);
                faddr = base_reg + UNIT_BYTES * live_runs[slot].first;
                sz    = live_runs[slot].size;
                live_runs.delete(slot);
                send_request(MODE_FREE, sz, rand48(), rand48(), faddr, now_tick);
            end else if (pick < 82) begin
                sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(1, 32))
                                                 : SIZE_W'($urandom_range(1, 12));
                case ($urandom_range(0, 2))
                    0: begin
                        lo = '0;
                        hi = ADDR_MAX;
                    end
                    1: begin
                        lo = base_reg;
                        hi = ADDR_MAX;
                    end
                    default: begin
                        lo = base_reg + UNIT_BYTES * $urandom_range(0, span) + $urandom_range(0, 3);
                        hi = lo + UNIT_BYTES * $urandom_range(0, 16);
                    end
                endcase
                send_request(MODE_ALLOC, sz, lo, hi, rand48(), now_tick);
            end else begin
                mode  = 1'($urandom_range(0, 1));
                faddr = $urandom_range(0, 1) ? rand48()
                                             : base_reg + $urandom_range(0, UNIT_BYTES * span + 8);
                if (mode == MODE_FREE)
                    stamp = now_tick + STAMP_W'($urandom_range(0, 20));
                else
                    stamp = $urandom_range(0, 1) ? STAMP_W'($urandom()) : now_tick;
                send_request(mode, SIZE_W'($urandom_range(0, 63)), rand48(), rand48(), faddr,
                             stamp);
            end
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [UIU_W-1:0] units,
                             input logic [DELAY_W-1:0] delay, input int step_max,
                             input int items, input logic no_stall);
        wait_for_grants();
        configure(base, units, delay);
        stall_free = no_stall;
        run_traffic(items, step_max);
        stall_free = 1'b0;
    endtask

    task automatic test_random_traffic();
        now_tick = 31'd400;
        run_phase('0, 9'd256, 8'd3, 2, 180, 1'b0);
        run_phase(rand48() & ~48'h3, UIU_W'($urandom_range(1, 64)), 8'd0, 1, 160, 1'b0);
        run_phase(rand48(), 9'd511, DELAY_W'($urandom_range(0, 10)), 3, 180, 1'b1);
        run_phase(rand48(), 9'd1, 8'd1, 3, 130, 1'b0);
        run_phase(ADDR_MAX, 9'd8, DELAY_W'($urandom_range(0, 255)), 10, 130, 1'b0);
        run_phase(rand48(), 9'd0, 8'd3, 1, 30, 1'b0);
        run_phase(48'hFFFF_FFFF_FF00, 9'd256, 8'd255, 40, 170, 1'b0);
        now_tick = 31'h7FFF_F000;
        run_phase(rand48(), UIU_W'($urandom_range(1, 256)), DELAY_W'($urandom_range(0, 255)),
                  20, 180, 1'b0);
    endtask

    initial begin
        foreach (mark_mirror[k])
            mark_mirror[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_size_limits();
        test_reuse_timing();
        test_wrapped_region();
        test_random_traffic();
        wait_for_grants();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (grant_errors == 0 && grant_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
